>>> hw/rtl/rcca_pkg.sv
// Shared types, codes and constants of the reference-counted cell allocator.
package rcca_pkg;

	localparam int CELLS = 1024;
	localparam int PW = $clog2(CELLS);
	localparam int LW = PW + 1;
	localparam int CW = 16;
	localparam int VW = 64;
	localparam int SW = 32;

	localparam logic [2:0] TAG_EMPTY   = 3'd0;
	localparam logic [2:0] TAG_UNALLOC = 3'd1;
	localparam logic [2:0] TAG_NUMBER  = 3'd2;
	localparam logic [2:0] TAG_SYMBOL  = 3'd3;
	localparam logic [2:0] TAG_PAIR    = 3'd4;
	localparam logic [2:0] TAG_FUNC    = 3'd5;

	typedef enum logic [3:0] {
		CMD_INIT     = 4'd0,
		CMD_CONS     = 4'd1,
		CMD_NUMBER   = 4'd2,
		CMD_SYMBOL   = 4'd3,
		CMD_CLOSURE  = 4'd4,
		CMD_INCREF   = 4'd5,
		CMD_DECREF   = 4'd6,
		CMD_READ     = 4'd7,
		CMD_SETCDR   = 4'd8,
		CMD_FREESIZE = 4'd9,
		CMD_EQ       = 4'd10
	} cmd_code_t;

	typedef enum logic [4:0] {
		DP_NOP,
		DP_CLR,
		DP_LOAD,
		DP_INIT0,
		DP_INIT1,
		DP_RD_A,
		DP_RD_B,
		DP_EQ,
		DP_READ_OUT,
		DP_SETCDR,
		DP_INC,
		DP_AL_RD,
		DP_AL_POP,
		DP_AL_FREE,
		DP_AL_SET,
		DP_REL_RD,
		DP_REL_WR,
		DP_SZ_A,
		DP_SZ_B,
		DP_MK_PAIR,
		DP_MK_FUNC,
		DP_MK_ATOM,
		DP_FL_STEP,
		DP_FL_END,
		DP_FL_OUT,
		DP_PUSH
	} dp_op_t;

	typedef enum logic [1:0] {
		REL_A,
		REL_B,
		REL_CAR,
		REL_LINK
	} rel_sel_t;

	typedef struct packed {
		logic [3:0]        command;
		logic [PW-1:0]     ptr_a;
		logic [PW-1:0]     ptr_b;
		logic signed [VW-1:0] value;
	} cmd_beat_t;

	typedef struct packed {
		logic [PW-1:0]     result_ptr;
		logic [2:0]        cell_tag;
		logic [PW-1:0]     car_ptr;
		logic [PW-1:0]     cdr_or_env_ptr;
		logic signed [VW-1:0] cell_value;
		logic [SW-1:0]     cell_size;
		logic [PW-1:0]     free_cells;
		logic              equal;
		logic              out_of_memory;
		logic              limit_error;
	} rsp_beat_t;

	typedef struct packed {
		dp_op_t   op;
		rel_sel_t rel_sel;
	} dp_ctl_t;

	typedef struct packed {
		logic [3:0] cmd;
		logic       path_rec;
		logic       path_free;
		logic [2:0] rd_tag;
		logic       r_zero;
		logic       fl_go;
		logic       clr_last;
		logic       out_free;
	} dp_sts_t;

endpackage

>>> hw/rtl/rcca_ctrl.sv
// Command sequencer of the cell allocator: steps the datapath through each command.
module rcca_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  rcca_pkg::dp_sts_t sts,
	output rcca_pkg::dp_ctl_t ctl
);
	import rcca_pkg::*;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_INIT0,
		S_INIT1,
		S_RD_A,
		S_USE_A,
		S_EQ,
		S_AL_RD,
		S_AL_DEC,
		S_REL_RD,
		S_REL_WR,
		S_AL_SET,
		S_SZ_A,
		S_SZ_B,
		S_MK_PAIR,
		S_MK_FUNC,
		S_MK_ATOM,
		S_FL_CHECK,
		S_FL_END,
		S_DONE
	} state_t;

	// What follows the release in progress.
	typedef enum logic [1:0] {
		K_DONE,
		K_ALSET,
		K_LINK_ALSET,
		K_B_DONE
	} cont_t;

	state_t   state_q;
	cont_t    cont_q;
	rel_sel_t sel_q;

	assign cmd_ready = (state_q == S_IDLE);

	always_comb begin
		ctl.op = DP_NOP;
		ctl.rel_sel = sel_q;
		case (state_q)
			S_CLEAR: ctl.op = DP_CLR;
			S_IDLE: begin
				if (cmd_valid) ctl.op = DP_LOAD;
			end
			S_INIT0: ctl.op = DP_INIT0;
			S_INIT1: ctl.op = DP_INIT1;
			S_RD_A: ctl.op = DP_RD_A;
			S_USE_A: begin
				case (sts.cmd)
					CMD_READ:   ctl.op = DP_READ_OUT;
					CMD_SETCDR: ctl.op = DP_SETCDR;
					CMD_INCREF: ctl.op = DP_INC;
					CMD_EQ:     ctl.op = DP_RD_B;
					default:    ctl.op = DP_NOP;
				endcase
			end
			S_EQ: ctl.op = DP_EQ;
			S_AL_RD: ctl.op = DP_AL_RD;
			S_AL_DEC: begin
				if (sts.path_rec) ctl.op = DP_AL_POP;
				else if (sts.path_free) ctl.op = DP_AL_FREE;
			end
			S_REL_RD: ctl.op = DP_REL_RD;
			S_REL_WR: ctl.op = DP_REL_WR;
			S_AL_SET: ctl.op = DP_AL_SET;
			S_SZ_A: ctl.op = DP_SZ_A;
			S_SZ_B: ctl.op = DP_SZ_B;
			S_MK_PAIR: ctl.op = DP_MK_PAIR;
			S_MK_FUNC: ctl.op = DP_MK_FUNC;
			S_MK_ATOM: ctl.op = DP_MK_ATOM;
			S_FL_CHECK: ctl.op = sts.fl_go ? DP_FL_STEP : DP_FL_OUT;
			S_FL_END: ctl.op = DP_FL_END;
			S_DONE: begin
				if (sts.out_free) ctl.op = DP_PUSH;
			end
			default: ctl.op = DP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cont_q <= K_DONE;
			sel_q <= REL_A;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (sts.clr_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (cmd_valid) state_q <= S_DISPATCH;
				end
				S_DISPATCH: begin
					case (sts.cmd)
						CMD_INIT: state_q <= S_INIT0;
						CMD_CONS, CMD_NUMBER, CMD_SYMBOL, CMD_CLOSURE: state_q <= S_AL_RD;
						CMD_INCREF, CMD_READ, CMD_SETCDR, CMD_EQ: state_q <= S_RD_A;
						CMD_DECREF: begin
							sel_q <= REL_A;
							cont_q <= K_DONE;
							state_q <= S_REL_RD;
						end
						CMD_FREESIZE: state_q <= S_FL_CHECK;
						default: state_q <= S_DONE;
					endcase
				end
				S_INIT0: state_q <= S_INIT1;
				S_INIT1: state_q <= S_DONE;
				S_RD_A: state_q <= S_USE_A;
				S_USE_A: state_q <= (sts.cmd == CMD_EQ) ? S_EQ : S_DONE;
				S_EQ: state_q <= S_DONE;
				S_AL_RD: state_q <= S_AL_DEC;
				S_AL_DEC: begin
					// A reused cell gives up its children before it is handed out.
					if (sts.path_rec && sts.rd_tag == TAG_FUNC) begin
						sel_q <= REL_LINK;
						cont_q <= K_ALSET;
						state_q <= S_REL_RD;
					end else if (sts.path_rec && sts.rd_tag == TAG_PAIR) begin
						sel_q <= REL_CAR;
						cont_q <= K_LINK_ALSET;
						state_q <= S_REL_RD;
					end else begin
						state_q <= S_AL_SET;
					end
				end
				S_REL_RD: state_q <= S_REL_WR;
				S_REL_WR: begin
					case (cont_q)
						K_LINK_ALSET: begin
							sel_q <= REL_LINK;
							cont_q <= K_ALSET;
							state_q <= S_REL_RD;
						end
						K_B_DONE: begin
							sel_q <= REL_B;
							cont_q <= K_DONE;
							state_q <= S_REL_RD;
						end
						K_ALSET: state_q <= S_AL_SET;
						default: state_q <= S_DONE;
					endcase
				end
				S_AL_SET: begin
					case (sts.cmd)
						CMD_CONS: begin
							if (sts.r_zero) begin
								sel_q <= REL_A;
								cont_q <= K_B_DONE;
								state_q <= S_REL_RD;
							end else begin
								state_q <= S_SZ_A;
							end
						end
						CMD_CLOSURE: begin
							if (sts.r_zero) begin
								sel_q <= REL_A;
								cont_q <= K_DONE;
								state_q <= S_REL_RD;
							end else begin
								state_q <= S_SZ_A;
							end
						end
						CMD_NUMBER, CMD_SYMBOL: state_q <= sts.r_zero ? S_DONE : S_MK_ATOM;
						CMD_FREESIZE: state_q <= S_SZ_A;
						default: state_q <= S_DONE;
					endcase
				end
				S_SZ_A: state_q <= (sts.cmd == CMD_CLOSURE) ? S_MK_FUNC : S_SZ_B;
				S_SZ_B: state_q <= S_MK_PAIR;
				S_MK_PAIR: state_q <= (sts.cmd == CMD_FREESIZE) ? S_FL_END : S_DONE;
				S_MK_FUNC: state_q <= S_DONE;
				S_MK_ATOM: state_q <= S_DONE;
				S_FL_CHECK: state_q <= sts.fl_go ? S_AL_RD : S_DONE;
				S_FL_END: state_q <= S_FL_CHECK;
				S_DONE: begin
					if (sts.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> hw/rtl/rcca_dp.sv
// Cell store, list registers and result register of the cell allocator.
module rcca_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rcca_pkg::dp_ctl_t      ctl,
	output rcca_pkg::dp_sts_t      sts,
	input  rcca_pkg::cmd_beat_t    cmd_beat,
	input  logic                   cfg_wr_en,
	input  logic [rcca_pkg::LW-1:0] cfg_wr_data,
	output logic                   rsp_valid,
	input  logic                   rsp_ready,
	output rcca_pkg::rsp_beat_t    rsp_beat
);
	import rcca_pkg::*;

	function automatic logic [SW-1:0] sat_inc_add(input logic [SW-1:0] x, input logic [SW-1:0] y);
		logic [SW+1:0] s;
		s = {2'b00, x} + {2'b00, y} + (SW+2)'(1);
		return (s[SW+1:SW] != 2'b00) ? {SW{1'b1}} : s[SW-1:0];
	endfunction

	// Cell store.
	logic [2:0]    tag_mem  [CELLS];
	logic [CW-1:0] cnt_mem  [CELLS];
	logic [VW-1:0] pay_mem  [CELLS];
	logic [PW-1:0] link_mem [CELLS];
	logic [SW-1:0] size_mem [CELLS];

	logic [2:0]    tag_rd_q;
	logic [CW-1:0] cnt_rd_q;
	logic [VW-1:0] pay_rd_q;
	logic [PW-1:0] link_rd_q;
	logic [SW-1:0] size_rd_q;

	logic [PW-1:0] rd_addr, wr_addr;
	logic          tag_we, cnt_we, pay_we, link_we, size_we;
	logic [2:0]    tag_wd;
	logic [CW-1:0] cnt_wd;
	logic [VW-1:0] pay_wd;
	logic [PW-1:0] link_wd;
	logic [SW-1:0] size_wd;

	// Control registers.
	logic [LW-1:0] fh_q, limit_q, cell_limit_q;
	logic [PW-1:0] reclaim_q, free_total_q, clr_q;
	logic          exceeded_q, rsp_valid_q;

	// Working registers.
	logic [3:0]    cmd_q;
	logic [LW-1:0] a_q, n_q;
	logic [PW-1:0] b_q, r_q, car_q, link_q, rel_q;
	logic [VW-1:0] v_q, x_pay_q;
	logic [2:0]    x_tag_q;
	logic [SW-1:0] size_a_q;
	logic          path_rec_q, path_free_q;
	rsp_beat_t     res_q, rsp_beat_q;

	logic          al_rec, al_free, al_fail_first, is_alloc_cmd, rel_dead;
	logic [LW-1:0] free_next, limit_clamped, fh_inc;
	logic [CW-1:0] neg_cnt, cnt_dec;
	logic [PW-1:0] rel_src;

	assign al_rec = (reclaim_q != '0);
	assign al_free = (fh_q < limit_q);
	assign al_fail_first = !al_rec && !al_free && !exceeded_q;
	assign is_alloc_cmd = (cmd_q == CMD_CONS) || (cmd_q == CMD_NUMBER) ||
		(cmd_q == CMD_SYMBOL) || (cmd_q == CMD_CLOSURE);

	// A dead cell keeps the negated index of the next dead cell in its count.
	assign neg_cnt = CW'(0) - cnt_rd_q;
	assign cnt_dec = cnt_rd_q - CW'(1);
	assign rel_dead = (rel_q != '0) && (cnt_dec == '0);
	assign fh_inc = fh_q + LW'(1);

	always_comb begin
		if (tag_rd_q == TAG_UNALLOC) free_next = fh_inc;
		else if (tag_rd_q == TAG_PAIR) free_next = pay_rd_q[LW-1:0];
		else free_next = '0;
	end

	always_comb begin
		if (cell_limit_q < LW'(4)) limit_clamped = LW'(4);
		else if (cell_limit_q > LW'(CELLS)) limit_clamped = LW'(CELLS);
		else limit_clamped = cell_limit_q;
	end

	always_comb begin
		case (ctl.rel_sel)
			REL_A:    rel_src = a_q[PW-1:0];
			REL_B:    rel_src = b_q;
			REL_CAR:  rel_src = car_q;
			REL_LINK: rel_src = link_q;
			default:  rel_src = a_q[PW-1:0];
		endcase
	end

	always_comb begin
		rd_addr = a_q[PW-1:0];
		wr_addr = '0;
		tag_we = 1'b0;
		tag_wd = TAG_EMPTY;
		cnt_we = 1'b0;
		cnt_wd = '0;
		pay_we = 1'b0;
		pay_wd = v_q;
		link_we = 1'b0;
		link_wd = b_q;
		size_we = 1'b0;
		size_wd = '0;
		case (ctl.op)
			DP_CLR: begin
				wr_addr = clr_q;
				tag_we = 1'b1;
				tag_wd = (clr_q == PW'(1)) ? TAG_UNALLOC : TAG_EMPTY;
				cnt_we = 1'b1;
				cnt_wd = (clr_q == '0) ? CW'(1) : '0;
				size_we = 1'b1;
			end
			DP_INIT0: begin
				tag_we = 1'b1;
				cnt_we = 1'b1;
				cnt_wd = CW'(1);
				size_we = 1'b1;
			end
			DP_INIT1: begin
				wr_addr = PW'(1);
				tag_we = 1'b1;
				tag_wd = TAG_UNALLOC;
			end
			DP_RD_B: rd_addr = b_q;
			DP_SETCDR: begin
				wr_addr = a_q[PW-1:0];
				link_we = (tag_rd_q == TAG_PAIR);
			end
			DP_INC: begin
				wr_addr = a_q[PW-1:0];
				cnt_we = 1'b1;
				cnt_wd = cnt_rd_q + CW'(1);
			end
			DP_AL_RD: rd_addr = al_rec ? reclaim_q : fh_q[PW-1:0];
			DP_AL_FREE: begin
				wr_addr = free_next[PW-1:0];
				tag_we = (tag_rd_q == TAG_UNALLOC) && (free_next < limit_q);
				tag_wd = TAG_UNALLOC;
			end
			DP_AL_SET: begin
				wr_addr = r_q;
				cnt_we = (r_q != '0);
				cnt_wd = CW'(1);
			end
			DP_REL_RD: rd_addr = rel_src;
			DP_REL_WR: begin
				wr_addr = rel_q;
				cnt_we = 1'b1;
				cnt_wd = rel_dead ? (CW'(0) - {{(CW-PW){1'b0}}, reclaim_q}) : cnt_dec;
			end
			DP_SZ_A: rd_addr = a_q[PW-1:0];
			DP_SZ_B: rd_addr = b_q;
			DP_MK_PAIR: begin
				wr_addr = r_q;
				tag_we = 1'b1;
				tag_wd = TAG_PAIR;
				pay_we = 1'b1;
				pay_wd = {{(VW-LW){1'b0}}, a_q};
				link_we = 1'b1;
				size_we = 1'b1;
				size_wd = sat_inc_add(size_a_q, size_rd_q);
			end
			DP_MK_FUNC: begin
				wr_addr = r_q;
				tag_we = 1'b1;
				tag_wd = TAG_FUNC;
				pay_we = 1'b1;
				link_we = 1'b1;
				link_wd = a_q[PW-1:0];
				size_we = 1'b1;
				size_wd = sat_inc_add(size_rd_q, '0);
			end
			DP_MK_ATOM: begin
				wr_addr = r_q;
				tag_we = 1'b1;
				tag_wd = (cmd_q == CMD_NUMBER) ? TAG_NUMBER : TAG_SYMBOL;
				pay_we = 1'b1;
				size_we = 1'b1;
				size_wd = SW'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (tag_we) tag_mem[wr_addr] <= tag_wd;
		if (cnt_we) cnt_mem[wr_addr] <= cnt_wd;
		if (pay_we) pay_mem[wr_addr] <= pay_wd;
		if (link_we) link_mem[wr_addr] <= link_wd;
		if (size_we) size_mem[wr_addr] <= size_wd;
		tag_rd_q <= tag_mem[rd_addr];
		cnt_rd_q <= cnt_mem[rd_addr];
		pay_rd_q <= pay_mem[rd_addr];
		link_rd_q <= link_mem[rd_addr];
		size_rd_q <= size_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fh_q <= LW'(1);
			reclaim_q <= '0;
			free_total_q <= PW'(CELLS - 1);
			exceeded_q <= 1'b0;
			cell_limit_q <= LW'(CELLS);
			limit_q <= LW'(CELLS);
			clr_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) cell_limit_q <= cfg_wr_data;
			if (ctl.op == DP_PUSH) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
			case (ctl.op)
				DP_CLR: clr_q <= clr_q + PW'(1);
				DP_INIT0: begin
					limit_q <= limit_clamped;
					free_total_q <= PW'(limit_clamped - LW'(1));
					fh_q <= LW'(1);
					reclaim_q <= '0;
					exceeded_q <= 1'b0;
				end
				DP_AL_RD: begin
					if (al_fail_first) exceeded_q <= 1'b1;
				end
				DP_AL_POP: reclaim_q <= neg_cnt[PW-1:0];
				DP_AL_FREE: begin
					fh_q <= free_next;
					free_total_q <= free_total_q - PW'(1);
				end
				DP_REL_WR: begin
					if (rel_dead) reclaim_q <= rel_q;
				end
				DP_FL_END: begin
					fh_q <= {1'b0, r_q};
					free_total_q <= free_total_q + PW'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			DP_LOAD: begin
				cmd_q <= cmd_beat.command;
				a_q <= {1'b0, cmd_beat.ptr_a};
				b_q <= cmd_beat.ptr_b;
				v_q <= cmd_beat.value;
				n_q <= '0;
				res_q <= '0;
			end
			DP_RD_B: begin
				x_tag_q <= tag_rd_q;
				x_pay_q <= pay_rd_q;
			end
			DP_EQ: begin
				res_q.equal <= (a_q[PW-1:0] == b_q) ||
					(x_tag_q == TAG_NUMBER && tag_rd_q == TAG_NUMBER && x_pay_q == pay_rd_q) ||
					(x_tag_q == TAG_SYMBOL && tag_rd_q == TAG_SYMBOL && x_pay_q == pay_rd_q);
			end
			DP_READ_OUT: begin
				res_q.cell_tag <= tag_rd_q;
				if (tag_rd_q == TAG_PAIR) res_q.car_ptr <= pay_rd_q[PW-1:0];
				if (tag_rd_q == TAG_PAIR || tag_rd_q == TAG_FUNC)
					res_q.cdr_or_env_ptr <= link_rd_q;
				if (tag_rd_q == TAG_NUMBER || tag_rd_q == TAG_SYMBOL || tag_rd_q == TAG_FUNC)
					res_q.cell_value <= pay_rd_q;
				res_q.cell_size <= size_rd_q;
			end
			DP_SETCDR: begin
				if (tag_rd_q == TAG_PAIR) res_q.result_ptr <= b_q;
			end
			DP_AL_RD: begin
				path_rec_q <= al_rec;
				path_free_q <= !al_rec && al_free;
				if (al_rec) r_q <= reclaim_q;
				else if (al_free) r_q <= fh_q[PW-1:0];
				else r_q <= '0;
				if (al_fail_first) res_q.limit_error <= 1'b1;
			end
			DP_AL_POP: begin
				car_q <= pay_rd_q[PW-1:0];
				link_q <= link_rd_q;
			end
			DP_REL_RD: rel_q <= rel_src;
			DP_AL_SET: begin
				if (is_alloc_cmd) begin
					res_q.result_ptr <= r_q;
					res_q.out_of_memory <= (r_q == '0);
				end
			end
			DP_SZ_B: size_a_q <= size_rd_q;
			DP_FL_STEP: begin
				a_q <= fh_q;
				b_q <= '0;
				n_q <= n_q + LW'(1);
			end
			DP_FL_OUT: res_q.free_cells <= free_total_q;
			DP_PUSH: rsp_beat_q <= res_q;
			default: ;
		endcase
	end

	assign sts.cmd = cmd_q;
	assign sts.path_rec = path_rec_q;
	assign sts.path_free = path_free_q;
	assign sts.rd_tag = tag_rd_q;
	assign sts.r_zero = (r_q == '0);
	assign sts.fl_go = al_rec && (n_q < LW'(CELLS));
	assign sts.clr_last = (clr_q == PW'(CELLS - 1));
	assign sts.out_free = !rsp_valid_q || rsp_ready;

	assign rsp_valid = rsp_valid_q;
	assign rsp_beat = rsp_beat_q;

	// Cell 0 is never pushed onto the reclaim list.
	a_nil_not_reclaimed: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == DP_REL_WR && rel_q == '0) |=> $stable(reclaim_q))
		else $error("empty list cell was reclaimed");

	// Taking a cell from the reclaim list always yields a real cell.
	a_reclaim_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == DP_AL_RD && reclaim_q != '0) |=> (r_q != '0))
		else $error("reclaim list produced cell 0");

	// The sticky failure flag and the first-failure report rise together.
	a_first_fail: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(exceeded_q) |-> res_q.limit_error)
		else $error("first allocation failure not reported");

	// Each flush step links a real cell in as the new free head.
	a_flush_head: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == DP_FL_END) |=> (fh_q != '0))
		else $error("flush step produced an empty free head");

endmodule

>>> hw/rtl/refcount_cell_allocator.sv
// Top level of the reference-counted cell allocator: sequencer plus cell store.
// A store of 1024 Lisp cells with 16-bit reference counts; cells freed by a
// decrement go onto a reclaim list and release their children only when reused.
// One command is worked at a time over a single-ported cell store, one access
// per cycle. A failing cons or closure allocation releases its operands, a
// reused cell releases its children before it is handed out, and freesize
// moves every reclaimed cell to the free chain, again releasing its children.
// After reset the block clears its tag, count and size stores before it takes
// the first command beat; cell_limit writes are taken at any time and applied
// by the init command. A result beat waiting in the output register does not
// stop the next command from being taken; a command only waits at its end
// while the previous result beat is still unread.
module refcount_cell_allocator (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cmd_valid,
	output logic                    cmd_ready,
	input  rcca_pkg::cmd_beat_t     cmd_beat,
	output logic                    rsp_valid,
	input  logic                    rsp_ready,
	output rcca_pkg::rsp_beat_t     rsp_beat,
	input  logic                    cfg_wr_en,
	input  logic [rcca_pkg::LW-1:0] cfg_wr_data
);
	import rcca_pkg::*;

	dp_ctl_t ctl;
	dp_sts_t sts;

	rcca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	rcca_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.cmd_beat    (cmd_beat),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp_beat    (rsp_beat)
	);

endmodule
